// ===== hw/rtl/tosr_pkg.sv =====
// Shared types and constants for the tagged operand stack.
// Holds beat structs, stack entry layout, operation and status codes.
// No dependencies.
package tosr_pkg;

  localparam int CNT_W = 13;

  // Operation codes carried in the kind field
  localparam logic [3:0] KIND_PUSH  = 4'd0;
  localparam logic [3:0] KIND_POP   = 4'd1;
  localparam logic [3:0] KIND_PEEK  = 4'd2;
  localparam logic [3:0] KIND_ROT   = 4'd3;
  localparam logic [3:0] KIND_SWAP  = 4'd4;
  localparam logic [3:0] KIND_DROP  = 4'd5;
  localparam logic [3:0] KIND_TEQ   = 4'd6;
  localparam logic [3:0] KIND_TMASK = 4'd7;
  localparam logic [3:0] KIND_VALID = 4'd8;

  // Result status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_ERR     = 2'd1;
  localparam logic [1:0] ST_IGNORED = 2'd2;
  localparam logic [1:0] ST_EMPTY   = 2'd3;

  // Handles of error entries
  localparam logic [31:0] ERR_TOO_FEW  = 32'd0;
  localparam logic [31:0] ERR_WRONG_TY = 32'd1;
  localparam logic [31:0] ERR_TOO_MANY = 32'd7;

  typedef struct packed {
    logic [31:0] handle;
    logic [4:0]  tag;
    logic [31:0] serial;
  } tosr_entry_t;

  typedef struct packed {
    logic [3:0]       kind;
    logic [31:0]      handle;
    logic [4:0]       tag;
    logic [31:0]      type_mask;
    logic [CNT_W-1:0] depth_arg;
  } tosr_in_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [31:0]      handle_out;
    logic [4:0]       tag_out;
    logic [31:0]      serial_out;
    logic [CNT_W-1:0] item_count;
    logic             match;
  } tosr_out_t;

endpackage

// ===== hw/rtl/tosr_ram.sv =====
// Stack entry memory: one write port, one read port, registered read data.
// Depends on tosr_pkg for the entry layout.
module tosr_ram #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [AW-1:0]        waddr,
  input  tosr_pkg::tosr_entry_t wdata,
  input  logic                 re,
  input  logic [AW-1:0]        raddr,
  output tosr_pkg::tosr_entry_t rdata
);

  tosr_pkg::tosr_entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Hold read data unless a new read is issued
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hw/rtl/tagged_operand_stack_with_rotate_top.sv =====
// Tagged operand stack top: control sequencer, counters and result register.
// Depends on tosr_pkg and tosr_ram.
// The accept cycle reads the needed entry and S_EXEC registers the result beat; a rotate
// or swap shifts entries through S_ROT, one entry per cycle through the single memory
// write port, then S_ROTEND. Throughput: one item in flight; a beat is taken only after the
// last one retires, which can wait on out_ready. Reset (synchronous, rst high): count, push
// counter and error tag clear; memory stays undefined and unwritten read data is never used.
module tagged_operand_stack_with_rotate_top #(
  parameter int STACK_DEPTH = 64
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  tosr_pkg::tosr_in_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output tosr_pkg::tosr_out_t out_data,
  input  logic                cfg_we,
  input  logic [4:0]          cfg_wdata
);

  localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int CW = tosr_pkg::CNT_W;
  // Above this count a push is discarded
  localparam logic [CW-1:0] NEAR_FULL = CW'(STACK_DEPTH - 5);
  // Below this count there is still room for the too-many error entry
  localparam logic [CW-1:0] ERR_ROOM  = CW'(STACK_DEPTH - 2);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_EXEC   = 4'b0010,
    S_ROT    = 4'b0100,
    S_ROTEND = 4'b1000
  } state_t;

  state_t                state;
  logic [CW-1:0]         count;
  logic [31:0]           push_total;
  logic [4:0]            error_tag;
  tosr_pkg::tosr_in_t    op;
  tosr_pkg::tosr_entry_t save;
  logic [AW-1:0]         wr_ptr;
  logic [AW-1:0]         top_ptr;

  // Memory port
  logic                  mem_we;
  logic [AW-1:0]         mem_waddr;
  tosr_pkg::tosr_entry_t mem_wdata;
  logic                  mem_re;
  logic [AW-1:0]         mem_raddr;
  tosr_pkg::tosr_entry_t rd_data;

  // Execute-stage decisions
  logic                  acc;
  logic                  out_free;
  logic                  out_load;
  logic [CW-1:0]         acc_addr;
  tosr_pkg::tosr_out_t   res;
  logic [CW-1:0]         count_next;
  logic [31:0]           total_next;
  logic                  push_do;
  logic [31:0]           push_h;
  logic [4:0]            push_t;
  logic                  ex_we;
  tosr_pkg::tosr_entry_t ex_wdata;
  logic                  go_rot;
  logic [CW-1:0]         rot_n;
  logic [CW-1:0]         rot_base;
  logic                  rot_last;
  tosr_pkg::tosr_out_t   rot_res;

  assign in_ready = (state == S_IDLE);
  assign acc      = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;
  assign rot_last = ((wr_ptr + AW'(1)) == top_ptr);
  // A result beat is loaded when an execute step or a shift retires
  assign out_load = out_free && ((state == S_EXEC && !go_rot) || state == S_ROTEND);

  // Address of the entry each operation needs, read in the accept cycle
  always_comb begin
    unique case (in_data.kind)
      tosr_pkg::KIND_PEEK: acc_addr = count - CW'(1) - in_data.depth_arg;
      tosr_pkg::KIND_ROT:  acc_addr = count - in_data.depth_arg;
      tosr_pkg::KIND_SWAP: acc_addr = count - CW'(2);
      default:             acc_addr = count - CW'(1);
    endcase
  end

  // Work out the result and state update from the read entry
  always_comb begin
    res        = '0;
    count_next = count;
    total_next = push_total;
    push_do    = 1'b0;
    push_h     = '0;
    push_t     = '0;
    go_rot     = 1'b0;
    rot_n      = op.depth_arg;
    ex_we      = 1'b0;
    ex_wdata   = '0;

    unique case (op.kind)
      tosr_pkg::KIND_PUSH: begin
        push_do = 1'b1;
        push_h  = op.handle;
        push_t  = op.tag;
      end
      tosr_pkg::KIND_POP: begin
        if (count == '0) begin
          push_do    = 1'b1;
          push_h     = tosr_pkg::ERR_TOO_FEW;
          push_t     = error_tag;
          res.status = tosr_pkg::ST_ERR;
        end else begin
          count_next     = count - CW'(1);
          res.handle_out = rd_data.handle;
          res.tag_out    = rd_data.tag;
          res.serial_out = rd_data.serial;
        end
      end
      tosr_pkg::KIND_PEEK: begin
        if (op.depth_arg < count) begin
          res.handle_out = rd_data.handle;
          res.tag_out    = rd_data.tag;
          res.serial_out = rd_data.serial;
        end else begin
          res.status = tosr_pkg::ST_EMPTY;
        end
      end
      tosr_pkg::KIND_ROT: begin
        if (op.depth_arg < CW'(2)) begin
          res.status = tosr_pkg::ST_IGNORED;
        end else if (count < op.depth_arg) begin
          push_do    = 1'b1;
          push_h     = tosr_pkg::ERR_TOO_FEW;
          push_t     = error_tag;
          res.status = tosr_pkg::ST_ERR;
        end else begin
          go_rot = 1'b1;
        end
      end
      tosr_pkg::KIND_SWAP: begin
        rot_n = CW'(2);
        if (count < CW'(2)) begin
          push_do    = 1'b1;
          push_h     = tosr_pkg::ERR_TOO_FEW;
          push_t     = error_tag;
          res.status = tosr_pkg::ST_ERR;
        end else begin
          go_rot = 1'b1;
        end
      end
      tosr_pkg::KIND_DROP: begin
        if (count == '0) begin
          push_do    = 1'b1;
          push_h     = tosr_pkg::ERR_TOO_FEW;
          push_t     = error_tag;
          res.status = tosr_pkg::ST_ERR;
        end else begin
          count_next = count - CW'(1);
        end
      end
      tosr_pkg::KIND_TEQ: begin
        if (count == '0) begin
          res.status = tosr_pkg::ST_EMPTY;
        end else begin
          res.match = (rd_data.tag == op.tag);
        end
      end
      tosr_pkg::KIND_TMASK: begin
        if (count == '0) begin
          res.status = tosr_pkg::ST_EMPTY;
        end else begin
          res.match = op.type_mask[rd_data.tag];
        end
      end
      tosr_pkg::KIND_VALID: begin
        if (count == '0) begin
          push_do    = 1'b1;
          push_h     = tosr_pkg::ERR_TOO_FEW;
          push_t     = error_tag;
          res.status = tosr_pkg::ST_ERR;
        end else if (op.type_mask[rd_data.tag]) begin
          res.match = 1'b1;
        end else begin
          push_do    = 1'b1;
          push_h     = tosr_pkg::ERR_WRONG_TY;
          push_t     = error_tag;
          res.status = tosr_pkg::ST_ERR;
        end
      end
      default: begin
        res.status = tosr_pkg::ST_EMPTY;
      end
    endcase

    // Shared push path for user entries and error entries
    if (push_do) begin
      if (count > NEAR_FULL) begin
        // Discarded entry still takes a serial; replace it by too-many if room
        res.status = tosr_pkg::ST_ERR;
        if (count < ERR_ROOM) begin
          total_next = push_total + 32'd2;
          ex_we      = 1'b1;
          ex_wdata   = '{handle: tosr_pkg::ERR_TOO_MANY, tag: error_tag,
                         serial: push_total + 32'd2};
          count_next = count + CW'(1);
        end else begin
          total_next = push_total + 32'd1;
        end
      end else begin
        total_next = push_total + 32'd1;
        ex_we      = 1'b1;
        ex_wdata   = '{handle: push_h, tag: push_t, serial: push_total + 32'd1};
        count_next = count + CW'(1);
      end
    end

    res.item_count = count_next;
  end

  assign rot_base = count - rot_n;

  always_comb begin
    rot_res            = '0;
    rot_res.status     = tosr_pkg::ST_OK;
    rot_res.item_count = count;
  end

  // Memory port steering by sequencer state
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = '0;
    mem_wdata = '0;
    mem_re    = 1'b0;
    mem_raddr = '0;
    unique case (state)
      S_IDLE: begin
        mem_re    = acc;
        mem_raddr = acc_addr[AW-1:0];
      end
      S_EXEC: begin
        mem_we    = ex_we && out_free;
        mem_waddr = count[AW-1:0];
        mem_wdata = ex_wdata;
        mem_re    = go_rot;
        mem_raddr = rot_base[AW-1:0] + AW'(1);
      end
      S_ROT: begin
        // Move entry wr_ptr+1 down one place, fetch the one after
        mem_we    = 1'b1;
        mem_waddr = wr_ptr;
        mem_wdata = rd_data;
        mem_re    = !rot_last;
        mem_raddr = wr_ptr + AW'(2);
      end
      S_ROTEND: begin
        // Drop the saved bottom entry onto the top
        mem_we    = 1'b1;
        mem_waddr = top_ptr;
        mem_wdata = save;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  tosr_ram #(
    .DEPTH (STACK_DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (rd_data)
  );

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      count      <= '0;
      push_total <= '0;
      error_tag  <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_we) begin
        error_tag <= cfg_wdata;
      end
      // Raise valid on a new result, drop it once the beat is taken
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (acc) begin
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (go_rot) begin
            state <= S_ROT;
          end else if (out_free) begin
            count      <= count_next;
            push_total <= total_next;
            state      <= S_IDLE;
          end
        end
        S_ROT: begin
          if (rot_last) begin
            state <= S_ROTEND;
          end
        end
        S_ROTEND: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (acc) begin
      op <= in_data;
    end
    if (state == S_EXEC && go_rot) begin
      save    <= rd_data;
      wr_ptr  <= rot_base[AW-1:0];
      top_ptr <= AW'(count - CW'(1));
    end
    if (state == S_ROT && !rot_last) begin
      wr_ptr <= wr_ptr + AW'(1);
    end
    if (state == S_EXEC && !go_rot && out_free) begin
      out_data <= res;
    end
    if (state == S_ROTEND && out_free) begin
      out_data <= rot_res;
    end
  end

  // The count never passes the too-many limit
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= ERR_ROOM)
    else $error("stack count above limit");

  // An accepted beat always goes straight to the execute step
  a_accept_exec: assert property (@(posedge clk) disable iff (rst)
    acc |=> state == S_EXEC)
    else $error("accepted beat not executed");

  // Count moves only when an execute step retires
  a_count_commit: assert property (@(posedge clk) disable iff (rst)
    !(state == S_EXEC && !go_rot && out_free) |=> $stable(count))
    else $error("count changed outside commit");

  // The shift never writes at or above the top entry
  a_rot_bound: assert property (@(posedge clk) disable iff (rst)
    state == S_ROT |-> wr_ptr < top_ptr)
    else $error("rotate shift out of range");

endmodule

// ===== test/tagged_operand_stack_with_rotate_top_tb.sv =====
// Self-checking testbench for the tagged operand stack with rotate.
// Drives operation beats, predicts every result beat and checks it field by field.
// Depends on tosr_pkg and the tagged_operand_stack_with_rotate_top RTL.
`timescale 1ns / 1ps

module tagged_operand_stack_with_rotate_top_tb;

  localparam int STACK_DEPTH = 64;

  typedef enum int {DRIFT_GROW, DRIFT_SHRINK, DRIFT_MIXED} drift_t;

  logic                clk = 1'b0;
  logic                rst;
  logic                in_valid;
  logic                in_ready;
  tosr_pkg::tosr_in_t  in_data;
  logic                out_valid;
  logic                out_ready;
  tosr_pkg::tosr_out_t out_data;
  logic                cfg_we;
  logic [4:0]          cfg_wdata;

  tagged_operand_stack_with_rotate_top #(
    .STACK_DEPTH(STACK_DEPTH)
  ) dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Stack mirror: entries, occupancy, push serial counter and error tag.
  logic [31:0] slot_handle [STACK_DEPTH];
  logic [4:0]  slot_tag    [STACK_DEPTH];
  logic [31:0] slot_serial [STACK_DEPTH];
  int          fill = 0;
  logic [31:0] serial_ctr = '0;
  logic [4:0]  model_err_tag = '0;

  // Result beats predicted but not yet seen, oldest first.
  tosr_pkg::tosr_out_t pending_results[$];

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int mismatches = 0;
  int results_checked = 0;
  int beats_sent = 0;
  int tag_writes = 0;
  int error_results = 0;
  int refused_pushes = 0;
  int rotations = 0;

  // ---------------------------------------------------------------------------
  // Stack mirror
  // ---------------------------------------------------------------------------

  // Every push burns a serial, even one that finds the store full.
  function automatic void place_entry(logic [31:0] h, logic [4:0] t);
    serial_ctr = serial_ctr + 32'd1;
    if (fill < STACK_DEPTH) begin
      slot_handle[fill] = h;
      slot_tag[fill]    = t;
      slot_serial[fill] = serial_ctr;
      fill++;
    end
  endfunction

  // Near the top a push is dropped (still burning a serial) and a too-many
  // error entry goes in instead, while there is still room for it.
  function automatic bit push_kept(logic [31:0] h, logic [4:0] t);
    if (fill > STACK_DEPTH - 5) begin
      serial_ctr = serial_ctr + 32'd1;
      refused_pushes++;
      if (fill < STACK_DEPTH - 2)
        place_entry(tosr_pkg::ERR_TOO_MANY, model_err_tag);
      return 1'b0;
    end
    place_entry(h, t);
    return 1'b1;
  endfunction

  function automatic void raise_error(logic [31:0] code);
    void'(push_kept(code, model_err_tag));
  endfunction

  // Lift the entry n deep to the top, sliding the ones above it down by one.
  function automatic void rotate_top(int n);
    logic [31:0] h;
    logic [31:0] s;
    logic [4:0]  t;
    int          base;
    base = fill - n;
    h = slot_handle[base];
    t = slot_tag[base];
    s = slot_serial[base];
    for (int i = base; i + 1 < fill; i++) begin
      slot_handle[i] = slot_handle[i + 1];
      slot_tag[i]    = slot_tag[i + 1];
      slot_serial[i] = slot_serial[i + 1];
    end
    slot_handle[fill - 1] = h;
    slot_tag[fill - 1]    = t;
    slot_serial[fill - 1] = s;
    rotations++;
  endfunction

  // Apply one operation to the mirror and return the result beat it must give.
  function automatic tosr_pkg::tosr_out_t predict_stack_op(tosr_pkg::tosr_in_t op);
    tosr_pkg::tosr_out_t r;
    logic [4:0]          top_tag;
    int                  k;
    r = '0;
    top_tag = (fill > 0) ? slot_tag[fill - 1] : '0;
    case (op.kind)
      tosr_pkg::KIND_PUSH: begin
        if (!push_kept(op.handle, op.tag)) r.status = tosr_pkg::ST_ERR;
      end
      tosr_pkg::KIND_POP, tosr_pkg::KIND_DROP: begin
        if (fill == 0) begin
          raise_error(tosr_pkg::ERR_TOO_FEW);
          r.status = tosr_pkg::ST_ERR;
        end else begin
          fill--;
          if (op.kind == tosr_pkg::KIND_POP) begin
            r.handle_out = slot_handle[fill];
            r.tag_out    = slot_tag[fill];
            r.serial_out = slot_serial[fill];
          end
        end
      end
      tosr_pkg::KIND_PEEK: begin
        if (int'(op.depth_arg) < fill) begin
          k = fill - 1 - int'(op.depth_arg);
          r.handle_out = slot_handle[k];
          r.tag_out    = slot_tag[k];
          r.serial_out = slot_serial[k];
        end else begin
          r.status = tosr_pkg::ST_EMPTY;
        end
      end
      tosr_pkg::KIND_ROT: begin
        if (op.depth_arg < 2) begin
          r.status = tosr_pkg::ST_IGNORED;
        end else if (fill < int'(op.depth_arg)) begin
          raise_error(tosr_pkg::ERR_TOO_FEW);
          r.status = tosr_pkg::ST_ERR;
        end else begin
          rotate_top(int'(op.depth_arg));
        end
      end
      tosr_pkg::KIND_SWAP: begin
        if (fill < 2) begin
          raise_error(tosr_pkg::ERR_TOO_FEW);
          r.status = tosr_pkg::ST_ERR;
        end else begin
          rotate_top(2);
        end
      end
      tosr_pkg::KIND_TEQ, tosr_pkg::KIND_TMASK: begin
        if (fill == 0) r.status = tosr_pkg::ST_EMPTY;
        else if (op.kind == tosr_pkg::KIND_TEQ) r.match = (top_tag == op.tag);
        else r.match = op.type_mask[top_tag];
      end
      tosr_pkg::KIND_VALID: begin
        if (fill == 0) begin
          raise_error(tosr_pkg::ERR_TOO_FEW);
          r.status = tosr_pkg::ST_ERR;
        end else if (op.type_mask[top_tag]) begin
          r.match = 1'b1;
        end else begin
          raise_error(tosr_pkg::ERR_WRONG_TY);
          r.status = tosr_pkg::ST_ERR;
        end
      end
      default: r.status = tosr_pkg::ST_EMPTY;
    endcase
    r.item_count = 13'(fill);
    if (r.status == tosr_pkg::ST_ERR) error_results++;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------

  function automatic void flag_failure(string msg);
    mismatches++;
    if (mismatches <= 10) $display("mismatch: %s", msg);
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got)
      flag_failure($sformatf("result %0d %s expected %0h got %0h",
                             results_checked, name, want, got));
  endfunction

  // Compare each result beat, sampled at the rising edge, with the oldest prediction.
  always @(posedge clk) begin
    tosr_pkg::tosr_out_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        flag_failure($sformatf("result beat %h with nothing expected", out_data));
      end else begin
        want = pending_results.pop_front();
        check_field("status",     32'(want.status),     32'(out_data.status));
        check_field("handle_out", want.handle_out,      out_data.handle_out);
        check_field("tag_out",    32'(want.tag_out),    32'(out_data.tag_out));
        check_field("serial_out", want.serial_out,      out_data.serial_out);
        check_field("item_count", 32'(want.item_count), 32'(out_data.item_count));
        check_field("match",      32'(want.match),      32'(out_data.match));
        results_checked++;
      end
    end
  end

  // Receiver: drop ready at random, at the falling edge only.
  always @(negedge clk) out_ready <= ($urandom_range(99) >= recv_idle_pct);

  // ---------------------------------------------------------------------------
  // Driving
  // ---------------------------------------------------------------------------

  // Enter and leave on a falling edge. Valid is only lowered when a gap is
  // taken, so back-to-back beats never lower and raise it in one step.
  task automatic send_op(input tosr_pkg::tosr_in_t item);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(negedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (!in_ready);
    pending_results.push_back(predict_stack_op(item));
    beats_sent++;
    @(negedge clk);
  endtask

  // Hold the sender off until every predicted beat has come back.
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending_results.size() != 0);
    // let the result register and handshake settle before touching config
    repeat (4) @(negedge clk);
  endtask

  task automatic write_error_tag(input logic [4:0] value);
    drain_results();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    model_err_tag = value;
    tag_writes++;
  endtask

  function automatic tosr_pkg::tosr_in_t make_op(logic [3:0] kind, logic [31:0] handle,
                                                 logic [4:0] tag, logic [31:0] mask,
                                                 logic [12:0] depth);
    tosr_pkg::tosr_in_t op;
    op.kind      = kind;
    op.handle    = handle;
    op.tag       = tag;
    op.type_mask = mask;
    op.depth_arg = depth;
    return op;
  endfunction

  // Random operation, biased by the current drift so the stack climbs to the
  // overflow guard, empties out, or wanders in between. Fields a kind does
  // not use stay random so that they are seen to be ignored.
  function automatic tosr_pkg::tosr_in_t random_stack_op(drift_t drift);
    tosr_pkg::tosr_in_t op;
    int                 roll;
    logic [4:0]         top_tag;
    top_tag = (fill > 0) ? slot_tag[fill - 1] : 5'($urandom_range(31));
    op.handle    = $urandom();
    op.tag       = 5'($urandom_range(31));
    op.type_mask = $urandom();
    op.depth_arg = 13'($urandom_range(8191));
    roll = $urandom_range(99);
    if (roll < 2) op.kind = 4'(tosr_pkg::KIND_VALID + $urandom_range(1, 7));
    else if (drift == DRIFT_GROW && roll < 72) op.kind = tosr_pkg::KIND_PUSH;
    else if (drift == DRIFT_SHRINK && roll < 62)
      op.kind = (roll < 32) ? tosr_pkg::KIND_POP : tosr_pkg::KIND_DROP;
    else if (drift == DRIFT_MIXED && roll < 25) op.kind = tosr_pkg::KIND_PUSH;
    else op.kind = 4'($urandom_range(tosr_pkg::KIND_VALID));
    roll = $urandom_range(99);
    case (op.kind)
      tosr_pkg::KIND_PUSH: if (roll < 25) op.tag = model_err_tag;
      tosr_pkg::KIND_PEEK: if (roll < 85) op.depth_arg = 13'($urandom_range(fill));
      tosr_pkg::KIND_ROT: begin
        if (roll < 10) op.depth_arg = 13'($urandom_range(1));
        else if (roll < 80 && fill >= 2) op.depth_arg = 13'($urandom_range(fill, 2));
        else if (roll < 90) op.depth_arg = 13'(fill + 1);
      end
      tosr_pkg::KIND_TEQ: if (roll < 50) op.tag = top_tag;
      tosr_pkg::KIND_TMASK, tosr_pkg::KIND_VALID: begin
        if (roll < 30) op.type_mask = 32'd1 << top_tag;
        else if (roll < 45) op.type_mask = ~(32'd1 << top_tag);
        else if (roll < 52) op.type_mask = '0;
        else if (roll < 59) op.type_mask = '1;
      end
      default: ;
    endcase
    return op;
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Operations that need entries, tried on a stack that starts empty.
  task automatic test_empty_stack_errors();
    send_op(make_op(tosr_pkg::KIND_TEQ,   '0, 5'd3, '0, '0));
    send_op(make_op(tosr_pkg::KIND_TMASK, '0, '0, '1, '0));
    send_op(make_op(tosr_pkg::KIND_VALID, '0, '0, '1, '0));
    send_op(make_op(tosr_pkg::KIND_POP,   '0, '0, '0, '0));
    send_op(make_op(tosr_pkg::KIND_POP,   '0, '0, '0, '0));
    send_op(make_op(tosr_pkg::KIND_DROP,  '0, '0, '0, '0));
    send_op(make_op(tosr_pkg::KIND_DROP,  '0, '0, '0, '0));
    send_op(make_op(tosr_pkg::KIND_SWAP,  '0, '0, '0, '0));
    send_op(make_op(tosr_pkg::KIND_PEEK,  '0, '0, '0, 13'd1));
    send_op(make_op(tosr_pkg::KIND_PEEK,  '0, '0, '0, 13'(fill)));
    send_op(make_op(tosr_pkg::KIND_PEEK,  '0, '0, '0, '1));
  endtask

  // Extreme handles and tags, then both outcomes of each tag test.
  task automatic test_push_peek_and_tags();
    send_op(make_op(tosr_pkg::KIND_PUSH,  '1, '1, '0, '0));
    send_op(make_op(tosr_pkg::KIND_PUSH,  '0, '0, '1, '1));
    send_op(make_op(tosr_pkg::KIND_PUSH,  32'h5A5A_A5A5, 5'd5, '0, '0));
    send_op(make_op(tosr_pkg::KIND_PEEK,  '0, '0, '0, 13'd2));
    send_op(make_op(tosr_pkg::KIND_TEQ,   '0, 5'd5, '0, '0));
    send_op(make_op(tosr_pkg::KIND_TEQ,   '0, 5'd4, '0, '0));
    send_op(make_op(tosr_pkg::KIND_TMASK, '0, '0, '1, '0));
    send_op(make_op(tosr_pkg::KIND_TMASK, '0, '0, ~(32'd1 << 5), '0));
    send_op(make_op(tosr_pkg::KIND_VALID, '0, '0, 32'd1 << 5, '0));
    send_op(make_op(tosr_pkg::KIND_VALID, '0, '0, ~(32'd1 << 5), '0));
  endtask

  // Rotate below two, the whole stack, one too many and the widest count.
  task automatic test_rotate_and_swap();
    send_op(make_op(tosr_pkg::KIND_ROT,  '0, '0, '0, 13'd0));
    send_op(make_op(tosr_pkg::KIND_ROT,  '0, '0, '0, 13'd1));
    send_op(make_op(tosr_pkg::KIND_ROT,  '0, '0, '0, 13'(fill)));
    send_op(make_op(tosr_pkg::KIND_ROT,  '0, '0, '0, 13'(fill + 1)));
    send_op(make_op(tosr_pkg::KIND_ROT,  '0, '0, '0, '1));
    send_op(make_op(tosr_pkg::KIND_SWAP, '0, '0, '0, '0));
    send_op(make_op(tosr_pkg::KIND_POP,  '0, '0, '0, '0));
  endtask

  task automatic test_unknown_kinds();
    send_op(make_op(4'(tosr_pkg::KIND_VALID + 1), '1, '1, '1, '1));
    send_op(make_op('1, '1, '1, '1, '1));
  endtask

  // Random traffic under one idling mix, with an error tag change halfway.
  task automatic test_random_traffic(input int send_pct, input int recv_pct,
                                     input int items, input logic [4:0] tag_a,
                                     input logic [4:0] tag_b);
    drift_t drift;
    int     run_left;
    int     roll;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    write_error_tag(tag_a);
    run_left = 0;
    drift = DRIFT_MIXED;
    for (int sent = 0; sent < items; sent++) begin
      if (sent == items / 2) write_error_tag(tag_b);
      if (run_left == 0) begin
        roll = $urandom_range(99);
        drift = (roll < 35) ? DRIFT_GROW : (roll < 65) ? DRIFT_SHRINK : DRIFT_MIXED;
        run_left = $urandom_range(80, 10);
      end
      run_left--;
      send_op(random_stack_op(drift));
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin
    rst       = 1'b1;
    in_valid  = 1'b0;
    in_data   = '0;
    out_ready = 1'b0;
    cfg_we    = 1'b0;
    cfg_wdata = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed part runs with no idling and the highest error tag
    write_error_tag('1);
    test_empty_stack_errors();
    test_push_peek_and_tags();
    test_rotate_and_swap();
    test_unknown_kinds();

    test_random_traffic(21, 53, 440, 5'($urandom_range(30, 1)), '0);
    test_random_traffic(53, 21, 440, '1, 5'($urandom_range(31)));
    test_random_traffic(0, 0, 440, '0, 5'($urandom_range(31)));

    // wait out the last results, then give a long rotate time to misbehave
    drain_results();
    repeat (100) @(posedge clk);
    if (pending_results.size() != 0)
      flag_failure($sformatf("%0d results never arrived", pending_results.size()));

    $display("covered %0d operation beats and %0d result beats over %0d error tag settings",
             beats_sent, results_checked, tag_writes);
    $display("%0d error results, %0d pushes refused near the top, %0d rotations applied",
             error_results, refused_pushes, rotations);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d mismatches in total", mismatches);
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Hard stop well beyond the slowest legal run.
  initial begin
    #10_000_000;
    $display("timeout with %0d results outstanding", pending_results.size());
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/tosr_pkg.sv
hw/rtl/tosr_ram.sv
hw/rtl/tagged_operand_stack_with_rotate_top.sv
test/tagged_operand_stack_with_rotate_top_tb.sv
